// File: sv/huffman_tree_bit_decoder_defines.svh
// assertion macros used by the tree-walk decoder rtl
`ifndef HUFFMAN_TREE_BIT_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_BIT_DECODER_DEFINES_SVH

// same-cycle implication, checked on clk, off while in reset
`define HTBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off while in reset
`define HTBD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/htbd_pkg.sv
// types, codes and helpers of the tree-walk decoder
package htbd_pkg;

  localparam int IDX_W   = 9;
  localparam int SYM_W   = 8;
  localparam int CNT_IN_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [SYM_W-1:0] sym_t;

  typedef enum logic [1:0] {
    OP_NODE  = 2'd0,
    OP_START = 2'd1,
    OP_DATA  = 2'd2
  } opcode_t;

  typedef struct packed {
    logic leaf;
    sym_t symbol;
    idx_t left;
    idx_t right;
  } entry_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    logic   re;
    idx_t   raddr;
  } mem_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BIT,
    S_CHILD,
    S_FLUSH
  } state_t;

  function automatic idx_t child_of(entry_t e, logic b);
    return b ? e.right : e.left;
  endfunction

endpackage

// File: sv/htbd_in_if.sv
// input item channel of the tree-walk decoder
interface htbd_in_if import htbd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  idx_t                node_index;
  logic                node_is_leaf;
  sym_t                node_symbol;
  idx_t                left_child;
  idx_t                right_child;
  logic [CNT_IN_W-1:0] symbol_count;
  logic [7:0]          data_byte;

  modport source (
    output valid, opcode, node_index, node_is_leaf, node_symbol,
           left_child, right_child, symbol_count, data_byte,
    input  ready
  );

  modport sink (
    input  valid, opcode, node_index, node_is_leaf, node_symbol,
           left_child, right_child, symbol_count, data_byte,
    output ready
  );
endinterface

// File: sv/htbd_out_if.sv
// result item channel of the tree-walk decoder
interface htbd_out_if import htbd_pkg::*; ();
  logic valid;
  logic ready;
  sym_t symbol;
  logic last_of_byte;
  logic stream_done;

  modport source (
    output valid, symbol, last_of_byte, stream_done,
    input  ready
  );

  modport sink (
    input  valid, symbol, last_of_byte, stream_done,
    output ready
  );
endinterface

// File: sv/huffman_tree_bit_decoder.sv
// top level of the huffman tree-walk decoder
// node write and start items are handled in the idle state; a data byte is walked bit by bit
// and no new item is accepted until it is done, with one node table read per bit in the child loop
// plus the S_BIT issue and S_FLUSH states, and the walk waits while the result channel stalls
// a symbol reaches the output register once the next symbol or the end of its byte is known
// reset clears the walk to the root, the symbol count and both valids; the table is not cleared
module huffman_tree_bit_decoder import htbd_pkg::*; #(
  parameter int NODE_ENTRIES = 512,
  parameter int COUNT_BITS   = 32
) (
  input logic         clk,
  input logic         rst_n,
  htbd_in_if.sink     in_if,
  htbd_out_if.source  out_if
);

  `include "huffman_tree_bit_decoder_defines.svh"

  state_t                 state_r, state_nxt;
  idx_t                   cur_node_r, cur_node_nxt;
  entry_t                 cur_ent_r, cur_ent_nxt;
  entry_t                 root_ent_r, root_ent_nxt;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [7:0]             byte_r, byte_nxt;
  logic [2:0]             bit_r, bit_nxt;
  idx_t                   nxt_r, nxt_nxt;
  logic                   hold_vld_r, hold_vld_nxt;
  sym_t                   hold_sym_r, hold_sym_nxt;
  logic                   hold_done_r, hold_done_nxt;
  logic                   out_vld_r, out_vld_nxt;
  sym_t                   out_sym_r, out_sym_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_done_r, out_done_nxt;

  mem_req_t               req;
  entry_t                 rd_ent;

  logic                   in_acc;
  logic                   out_free;
  logic                   emit_ok;
  entry_t                 w_ent;
  logic                   w_in_range;
  logic [COUNT_BITS-1:0]  cnt_dec;
  logic                   b_more;
  idx_t                   b_child;
  logic                   f_leaf;
  logic [COUNT_BITS-1:0]  c_cnt;
  entry_t                 c_ent;
  logic                   c_more;
  logic [2:0]             bit_dec;
  idx_t                   c_child;
  logic                   emit;
  sym_t                   emit_sym;
  logic                   emit_done;
  logic                   push;
  sym_t                   push_sym;
  logic                   push_last;
  logic                   push_done;

  htbd_node_mem #(.NODE_ENTRIES(NODE_ENTRIES)) u_mem (
    .clk    (clk),
    .req    (req),
    .rd_ent (rd_ent)
  );

  assign in_if.ready         = (state_r == S_IDLE);
  assign in_acc              = in_if.valid && in_if.ready;
  assign out_free            = !out_vld_r || out_if.ready;
  assign emit_ok             = !hold_vld_r || out_free;

  assign w_ent.leaf          = in_if.node_is_leaf;
  assign w_ent.symbol        = in_if.node_symbol;
  assign w_ent.left          = in_if.left_child;
  assign w_ent.right         = in_if.right_child;
  assign w_in_range          = 32'(in_if.node_index) < 32'(NODE_ENTRIES);

  assign cnt_dec             = cnt_r - COUNT_BITS'(1);
  assign bit_dec             = bit_r - 3'd1;
  assign b_more              = (bit_r != 3'd0) && (cnt_dec != '0);
  assign b_child             = child_of(cur_ent_r, byte_r[bit_r]);
  assign f_leaf              = rd_ent.leaf;
  assign c_cnt               = f_leaf ? cnt_dec : cnt_r;
  assign c_ent               = f_leaf ? root_ent_r : rd_ent;
  assign c_more              = (bit_r != 3'd0) && (c_cnt != '0);
  assign c_child             = child_of(c_ent, byte_r[bit_dec]);

  assign out_if.valid        = out_vld_r;
  assign out_if.symbol       = out_sym_r;
  assign out_if.last_of_byte = out_last_r;
  assign out_if.stream_done  = out_done_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_if.opcode == OP_DATA) && (cnt_r != '0)) begin
          state_nxt = S_BIT;
        end
      end
      S_BIT: begin
        if (!cur_ent_r.leaf) begin
          state_nxt = S_CHILD;
        end else if (emit_ok) begin
          state_nxt = b_more ? S_BIT : S_FLUSH;
        end
      end
      S_CHILD: begin
        if (!f_leaf || emit_ok) begin
          if (!c_more) begin
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = c_ent.leaf ? S_BIT : S_CHILD;
          end
        end
      end
      S_FLUSH: begin
        if (!hold_vld_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cur_node_nxt  = cur_node_r;
    cur_ent_nxt   = cur_ent_r;
    root_ent_nxt  = root_ent_r;
    cnt_nxt       = cnt_r;
    byte_nxt      = byte_r;
    bit_nxt       = bit_r;
    nxt_nxt       = nxt_r;
    hold_vld_nxt  = hold_vld_r;
    hold_sym_nxt  = hold_sym_r;
    hold_done_nxt = hold_done_r;
    req           = '0;
    emit          = 1'b0;
    emit_sym      = cur_ent_r.symbol;
    emit_done     = 1'b0;
    push          = 1'b0;
    push_sym      = hold_sym_r;
    push_last     = 1'b0;
    push_done     = hold_done_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_if.opcode)
            OP_NODE: begin
              req.we    = w_in_range;
              req.waddr = in_if.node_index;
              req.wdata = w_ent;
              if (w_in_range && (in_if.node_index == '0)) begin
                root_ent_nxt = w_ent;
              end
              if (w_in_range && (in_if.node_index == cur_node_r)) begin
                cur_ent_nxt = w_ent;
              end
            end
            OP_START: begin
              cnt_nxt      = COUNT_BITS'(in_if.symbol_count);
              cur_node_nxt = '0;
              cur_ent_nxt  = root_ent_r;
            end
            OP_DATA: begin
              byte_nxt = in_if.data_byte;
              bit_nxt  = 3'd7;
            end
            default: ;
          endcase
        end
      end
      S_BIT: begin
        if (!cur_ent_r.leaf) begin
          req.re    = 1'b1;
          req.raddr = b_child;
          nxt_nxt   = b_child;
        end else if (emit_ok) begin
          emit         = 1'b1;
          emit_sym     = cur_ent_r.symbol;
          emit_done    = (cnt_dec == '0);
          cur_node_nxt = '0;
          cur_ent_nxt  = root_ent_r;
          cnt_nxt      = cnt_dec;
          bit_nxt      = bit_dec;
        end
      end
      S_CHILD: begin
        if (!f_leaf || emit_ok) begin
          emit         = f_leaf;
          emit_sym     = rd_ent.symbol;
          emit_done    = (c_cnt == '0);
          cur_node_nxt = f_leaf ? '0 : nxt_r;
          cur_ent_nxt  = c_ent;
          cnt_nxt      = c_cnt;
          bit_nxt      = bit_dec;
          if (c_more && !c_ent.leaf) begin
            req.re    = 1'b1;
            req.raddr = c_child;
            nxt_nxt   = c_child;
          end
        end
      end
      S_FLUSH: begin
        if (hold_vld_r && out_free) begin
          push         = 1'b1;
          push_last    = 1'b1;
          hold_vld_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    // the held symbol is not last once another one follows in the same byte
    if (emit) begin
      if (hold_vld_r) begin
        push      = 1'b1;
        push_last = 1'b0;
      end
      hold_vld_nxt  = 1'b1;
      hold_sym_nxt  = emit_sym;
      hold_done_nxt = emit_done;
    end

    out_sym_nxt  = out_sym_r;
    out_last_nxt = out_last_r;
    out_done_nxt = out_done_r;
    if (push) begin
      out_vld_nxt  = 1'b1;
      out_sym_nxt  = push_sym;
      out_last_nxt = push_last;
      out_done_nxt = push_done;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cur_node_r <= '0;
      cnt_r      <= '0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_node_r <= cur_node_nxt;
      cnt_r      <= cnt_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_ent_r   <= cur_ent_nxt;
    root_ent_r  <= root_ent_nxt;
    byte_r      <= byte_nxt;
    bit_r       <= bit_nxt;
    nxt_r       <= nxt_nxt;
    hold_sym_r  <= hold_sym_nxt;
    hold_done_r <= hold_done_nxt;
    out_sym_r   <= out_sym_nxt;
    out_last_r  <= out_last_nxt;
    out_done_r  <= out_done_nxt;
  end

  `HTBD_ASSERT_IMP(a_done_empties_count, hold_vld_r && hold_done_r, cnt_r == '0, "held final symbol with count left")
  `HTBD_ASSERT_IMP(a_zero_count_no_walk, cnt_r == '0, state_r == S_IDLE || state_r == S_FLUSH, "walk running with zero count")
  `HTBD_ASSERT_IMP(a_idle_hold_empty, state_r == S_IDLE, !hold_vld_r, "symbol left in hold while idle")
  `HTBD_ASSERT_NXT(a_data_starts_walk, in_acc && in_if.opcode == OP_DATA && cnt_r != '0, state_r == S_BIT, "data item did not start walk")

endmodule

// File: sv/htbd_node_mem.sv
// node table memory, one write and one registered read port, zero beyond the table
module htbd_node_mem import htbd_pkg::*; #(
  parameter int NODE_ENTRIES = 512
) (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_ent
);

  localparam int AW = $clog2(NODE_ENTRIES);

  entry_t mem [NODE_ENTRIES];
  entry_t rdata_r;
  logic   roor_r;
  logic   w_in;
  logic   r_in;

  assign w_in = 32'(req.waddr) < 32'(NODE_ENTRIES);
  assign r_in = 32'(req.raddr) < 32'(NODE_ENTRIES);

  always_ff @(posedge clk) begin
    if (req.we && w_in) begin
      mem[AW'(req.waddr)] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[AW'(req.raddr)];
      roor_r  <= !r_in;
    end
  end

  assign rd_ent = roor_r ? '0 : rdata_r;

endmodule
